// ===== design/sound_board_mailbox_and_irq_assert.svh =====
// Assertion macros shared by the sound board interface RTL.
// All are clocked on clk and disabled while arst_n is low.
`ifndef SOUND_BOARD_MAILBOX_AND_IRQ_ASSERT_SVH
`define SOUND_BOARD_MAILBOX_AND_IRQ_ASSERT_SVH

// same-cycle implication
`define SBMI_ASSERT_NOW(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("sbmi same-cycle check failed");

// next-cycle implication
`define SBMI_ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("sbmi next-cycle check failed");

`endif

// ===== design/sbmi_pkg.sv =====
package sbmi_pkg;

	// item modes
	localparam logic [2:0] MODE_HOST_WR = 3'd0;
	localparam logic [2:0] MODE_HOST_RD = 3'd1;
	localparam logic [2:0] MODE_SND_WR  = 3'd2;
	localparam logic [2:0] MODE_SND_RD  = 3'd3;
	localparam logic [2:0] MODE_TICK    = 3'd4;
	localparam logic [2:0] MODE_RESET   = 3'd5;

	// sound chip access kinds
	localparam logic [1:0] ACC_NONE  = 2'd0;
	localparam logic [1:0] ACC_WRITE = 2'd1;
	localparam logic [1:0] ACC_READ  = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_DIP     = 2'd0;
	localparam logic [1:0] CFG_PERIOD  = 2'd1;
	localparam logic [1:0] CFG_MASK_LO = 2'd2;
	localparam logic [1:0] CFG_MASK_HI = 2'd3;

	// sound side decode, top address nibble
	localparam logic [3:0] HI_STATUS = 4'hc;
	localparam logic [3:0] HI_ONES   = 4'he;
	localparam logic [3:0] HI_DIP    = 4'hf;
	localparam logic [3:0] HI_CHIP1  = 4'hb;

	// sound side decode under mask 0xf003
	localparam logic [15:0] DEC_MASK     = 16'hf003;
	localparam logic [15:0] DEC_MAILBOX  = 16'h9000;
	localparam logic [15:0] DEC_C0_LATCH = 16'ha000;
	localparam logic [15:0] DEC_C0_DATA  = 16'ha002;
	localparam logic [15:0] DEC_C1_LATCH = 16'hb000;
	localparam logic [15:0] DEC_C1_DATA  = 16'hb002;
	localparam logic [15:0] DEC_C0_READ  = 16'ha001;
	localparam logic [15:0] DEC_C1_READ  = 16'hb001;

	// host side decode
	localparam logic [7:0] HOST_PORT_LAST = 8'h07;
	localparam logic [5:0] HOST_MAILBOX   = 6'h07;
	localparam logic [7:0] HOST_RD_MASK   = 8'he7;
	localparam logic [7:0] HOST_EXT_LAST  = 8'h04;
	localparam logic [7:0] HOST_STATUS    = 8'h07;

	typedef struct packed {
		logic [2:0]  mode;
		logic [15:0] address;
		logic [7:0]  data;
		logic [7:0]  ext_data;
		logic        reset_level;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq_pulse;
		logic       sound_reset;
		logic [1:0] chip_access;
		logic       chip_select;
		logic       chip_is_data;
		logic [7:0] write_value;
		logic       out_port_strobe;
		logic [2:0] out_port_index;
	} result_t;

	typedef struct packed {
		logic [7:0]  dip;
		logic [15:0] period;
		logic [7:0]  mask_lo;
		logic [7:0]  mask_hi;
	} cfg_t;

endpackage

// ===== design/sbmi_cfg.sv =====
module sbmi_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output sbmi_pkg::cfg_t     cfg
);

	sbmi_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dip     <= 8'h00;
			cfg_q.period  <= 16'd1;
			cfg_q.mask_lo <= 8'hff;
			cfg_q.mask_hi <= 8'hff;
		end else if (cfg_we) begin
			case (cfg_index)
				sbmi_pkg::CFG_DIP:     cfg_q.dip     <= cfg_data[7:0];
				sbmi_pkg::CFG_PERIOD:  cfg_q.period  <= cfg_data;
				sbmi_pkg::CFG_MASK_LO: cfg_q.mask_lo <= cfg_data[7:0];
				sbmi_pkg::CFG_MASK_HI: cfg_q.mask_hi <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/sbmi_core.sv =====
module sbmi_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  sbmi_pkg::item_t     item,
	input  sbmi_pkg::cfg_t      cfg,
	output sbmi_pkg::result_t   res
);

	logic [7:0]  mailbox_q [4];
	logic [7:0]  status_q;
	logic [15:0] tick_q;
	logic        rline_q;

	logic [7:0]  mailbox_d [4];
	logic [7:0]  status_d;
	logic [15:0] tick_d;
	logic        rline_d;

	logic [7:0]  a8;
	logic [3:0]  hi;
	logic [15:0] dec;
	logic [7:0]  host_a;
	logic [16:0] tick_nxt;

	assign a8       = item.address[7:0];
	assign hi       = item.address[15:12];
	assign dec      = item.address & sbmi_pkg::DEC_MASK;
	assign host_a   = a8 & sbmi_pkg::HOST_RD_MASK;
	assign tick_nxt = {1'b0, tick_q} + 17'd1;

	always_comb begin
		res       = '0;
		mailbox_d = mailbox_q;
		status_d  = status_q;
		tick_d    = tick_q;
		rline_d   = rline_q;
		case (item.mode)
			sbmi_pkg::MODE_HOST_WR: begin
				if (a8 <= sbmi_pkg::HOST_PORT_LAST) begin
					res.out_port_strobe = 1'b1;
					res.out_port_index  = a8[2:0];
					res.write_value     = item.data & (a8[2] ? cfg.mask_hi : cfg.mask_lo);
				end else if (a8[7:2] == sbmi_pkg::HOST_MAILBOX) begin
					mailbox_d[a8[1:0]] = item.data;
				end
			end
			sbmi_pkg::MODE_HOST_RD: begin
				if (host_a <= sbmi_pkg::HOST_EXT_LAST)
					res.read_data = item.ext_data;
				else if (host_a == sbmi_pkg::HOST_STATUS)
					res.read_data = status_q;
				else
					res.read_data = 8'hff;
			end
			sbmi_pkg::MODE_SND_WR: begin
				if (hi == sbmi_pkg::HI_STATUS) begin
					status_d = item.data;
				end else if (dec == sbmi_pkg::DEC_C0_LATCH || dec == sbmi_pkg::DEC_C0_DATA ||
					dec == sbmi_pkg::DEC_C1_LATCH || dec == sbmi_pkg::DEC_C1_DATA) begin
					res.chip_access  = sbmi_pkg::ACC_WRITE;
					res.chip_select  = (dec[15:12] == sbmi_pkg::HI_CHIP1);
					res.chip_is_data = dec[1];
					res.write_value  = item.data;
				end
			end
			sbmi_pkg::MODE_SND_RD: begin
				if (hi == sbmi_pkg::HI_STATUS)
					res.read_data = 8'h00;
				else if (hi == sbmi_pkg::HI_ONES)
					res.read_data = 8'hff;
				else if (hi == sbmi_pkg::HI_DIP)
					res.read_data = cfg.dip;
				else if ((dec & 16'hfffc) == sbmi_pkg::DEC_MAILBOX)
					res.read_data = mailbox_q[item.address[1:0]];
				else if (dec == sbmi_pkg::DEC_C0_READ || dec == sbmi_pkg::DEC_C1_READ) begin
					res.chip_access = sbmi_pkg::ACC_READ;
					res.chip_select = (dec == sbmi_pkg::DEC_C1_READ);
					res.read_data   = item.ext_data;
				end
			end
			sbmi_pkg::MODE_TICK: begin
				// zero period pulses on every tick; a lowered period catches up at once
				if (tick_nxt >= {1'b0, cfg.period}) begin
					res.irq_pulse = 1'b1;
					tick_d        = 16'd0;
				end else begin
					tick_d = tick_nxt[15:0];
				end
			end
			sbmi_pkg::MODE_RESET: begin
				rline_d = item.reset_level;
				if (item.reset_level) begin
					mailbox_d = '{default: 8'h00};
					status_d  = 8'h00;
					tick_d    = 16'd0;
				end
			end
			default: ;
		endcase
		res.sound_reset = rline_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mailbox_q <= '{default: 8'h00};
			status_q  <= 8'h00;
			tick_q    <= 16'd0;
			rline_q   <= 1'b0;
		end else if (fire) begin
			mailbox_q <= mailbox_d;
			status_q  <= status_d;
			tick_q    <= tick_d;
			rline_q   <= rline_d;
		end
	end

`include "sound_board_mailbox_and_irq_assert.svh"

	`SBMI_ASSERT_NEXT(a_irq_clears_count, fire && res.irq_pulse, tick_q == 16'd0)
	`SBMI_ASSERT_NEXT(a_reset_clears, fire && item.mode == sbmi_pkg::MODE_RESET && item.reset_level, status_q == 8'h00 && tick_q == 16'd0 && rline_q)
	`SBMI_ASSERT_NOW(a_strobe_excl, res.out_port_strobe, res.chip_access == sbmi_pkg::ACC_NONE && res.read_data == 8'h00)
	`SBMI_ASSERT_NEXT(a_mailbox_write, fire && item.mode == sbmi_pkg::MODE_HOST_WR && a8[7:2] == sbmi_pkg::HOST_MAILBOX, mailbox_q[$past(a8[1:0])] == $past(item.data))

endmodule

// ===== design/sound_board_mailbox_and_irq.sv =====
// Sound board host/sound-CPU interface with four byte mailboxes and a periodic IRQ.
// Input channel (in_valid/in_ready): one bus access or event per transfer, selected
// by mode: host write, host read, sound write, sound read, tick, reset level.
// Output channel (out_valid/out_ready): exactly one result per input transfer,
// carrying read data, the irq pulse, the reset line level and chip/port strobes.
// Config port: cfg_we writes cfg_index (0 dip, 1 irq period, 2 low mask,
// 3 high mask) with cfg_data; write only while idle.
// Each input is held in the input register, and its result in the result register.
// Throughput: one item per cycle while out_ready holds, set by the single decode/update pass
// between the input register and the result register.
// When the receiver stalls, the result register holds and the input register
// still takes an item if it is empty; once full, in_ready drops until out_ready returns.
// Reset (arst_n low) empties both registers, clears mailboxes, status byte,
// tick count and reset line, and loads period 1, masks 0xff and dip 0.
module sound_board_mailbox_and_irq (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  mode,
	input  logic [15:0] address,
	input  logic [7:0]  data,
	input  logic [7:0]  ext_data,
	input  logic        reset_level,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  read_data,
	output logic        irq_pulse,
	output logic        sound_reset,
	output logic [1:0]  chip_access,
	output logic        chip_select,
	output logic        chip_is_data,
	output logic [7:0]  write_value,
	output logic        out_port_strobe,
	output logic [2:0]  out_port_index,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	sbmi_pkg::item_t   item_s1;
	logic              valid_s1;
	sbmi_pkg::result_t res_s2;
	logic              valid_s2;
	sbmi_pkg::result_t res;
	sbmi_pkg::cfg_t    cfg;
	logic              adv;
	logic              in_xfer;

	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign in_xfer  = in_valid && in_ready;

	sbmi_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sbmi_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (adv)
				valid_s2 <= 1'b1;
			else if (out_ready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer)
			item_s1 <= '{mode: mode, address: address, data: data,
				ext_data: ext_data, reset_level: reset_level};
		if (adv)
			res_s2 <= res;
	end

	assign out_valid       = valid_s2;
	assign read_data       = res_s2.read_data;
	assign irq_pulse       = res_s2.irq_pulse;
	assign sound_reset     = res_s2.sound_reset;
	assign chip_access     = res_s2.chip_access;
	assign chip_select     = res_s2.chip_select;
	assign chip_is_data    = res_s2.chip_is_data;
	assign write_value     = res_s2.write_value;
	assign out_port_strobe = res_s2.out_port_strobe;
	assign out_port_index  = res_s2.out_port_index;

`include "sound_board_mailbox_and_irq_assert.svh"

	`SBMI_ASSERT_NEXT(a_adv_fills_s2, adv, valid_s2)
	`SBMI_ASSERT_NEXT(a_stall_keeps_s1, valid_s1 && valid_s2 && !out_ready, valid_s1 && valid_s2)

endmodule
